[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers used by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[rtl/pwp_pkg.sv]
// ---------------------------------------------------------------------------
// pwp_pkg
// shared types and constants of the partition write protect check
// ---------------------------------------------------------------------------
package pwp_pkg;

  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned ENTRY_W       = 5;
  localparam int unsigned COUNT_W       = 5;
  localparam int unsigned SECTOR_SHIFT  = 9;
  // table word: writable flag above the start sector
  localparam int unsigned WORD_W        = ADDR_W + 1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = COUNT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_ALLOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ADDRESSED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_COUNT = 2'd2;

  typedef enum logic [1:0] {
    ACT_CHECK   = 2'd0,
    ACT_LOAD    = 2'd1,
    ACT_MARK_WR = 2'd2,
    ACT_MARK_RO = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               force_allow;
    logic               block_addressed;
    logic [COUNT_W-1:0] partition_count;
  } cfg_t;

endpackage

[rtl/pwp_in_if.sv]
// ---------------------------------------------------------------------------
// pwp_in_if
// request channel: action, entry index and address
// ---------------------------------------------------------------------------
interface pwp_in_if;
  import pwp_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [ENTRY_W-1:0] entry_index;
  logic [ADDR_W-1:0]  address;

  modport source (output valid, output action, output entry_index, output address,
                  input ready);
  modport sink   (input valid, input action, input entry_index, input address,
                  output ready);
endinterface

[rtl/pwp_out_if.sv]
// ---------------------------------------------------------------------------
// pwp_out_if
// result channel: writable and violation flags
// ---------------------------------------------------------------------------
interface pwp_out_if;
  logic valid;
  logic ready;
  logic writable;
  logic violation;

  modport source (output valid, output writable, output violation, input ready);
  modport sink   (input valid, input writable, input violation, output ready);
endinterface

[rtl/pwp_ram.sv]
// ---------------------------------------------------------------------------
// pwp_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module pwp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pwp_cfg.sv]
// ---------------------------------------------------------------------------
// pwp_cfg
// configuration registers written through the plain write port
// ---------------------------------------------------------------------------
module pwp_cfg import pwp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FORCE_ALLOW:     cfg_d.force_allow     = cfg_wdata_i[0];
        CFG_BLOCK_ADDRESSED: cfg_d.block_addressed = cfg_wdata_i[0];
        CFG_PARTITION_COUNT: cfg_d.partition_count = cfg_wdata_i[COUNT_W-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.force_allow     <= 1'b0;
      cfg_q.block_addressed <= 1'b1;
      cfg_q.partition_count <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/pwp_scan.sv]
// ---------------------------------------------------------------------------
// pwp_scan
// item sequencer: table updates, downward scan and result register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pwp_scan import pwp_pkg::*; #(
  parameter int unsigned MaxParts = 32,
  localparam int unsigned IdxW = $clog2(MaxParts)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  pwp_in_if.sink            in_i,
  pwp_out_if.source         out_o,
  // table ram
  output logic              ram_we_o,
  output logic [IdxW-1:0]   ram_waddr_o,
  output logic [WORD_W-1:0] ram_wdata_o,
  output logic              ram_re_o,
  output logic [IdxW-1:0]   ram_raddr_o,
  input  logic [WORD_W-1:0] ram_rdata_i
);

  localparam int unsigned TopMax = MaxParts - 1;

  state_e state_q, state_d;

  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [IdxW-1:0]   k_q, k_d;
  logic              mark_wr_q, mark_wr_d;
  logic              res_wr_q, res_wr_d;
  logic [MaxParts-1:0] loaded_q, loaded_d;

  logic              out_valid_q, out_valid_d;
  logic              writable_q, writable_d;
  logic              violation_q, violation_d;

  logic              in_fire;
  action_e           act;
  logic              in_range;
  logic [IdxW+ENTRY_W-1:0] idx_wide;
  logic [IdxW-1:0]   idx;
  logic [IdxW+COUNT_W-1:0] cnt_wide;
  logic [IdxW-1:0]   top;
  logic [ADDR_W-1:0] sector;
  logic              hit;
  logic              out_free;

  assign act        = action_e'(in_i.action);
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_range   = 32'(in_i.entry_index) < 32'(MaxParts);
  assign idx_wide   = {{IdxW{1'b0}}, in_i.entry_index};
  assign idx        = idx_wide[IdxW-1:0];
  assign cnt_wide   = {{IdxW{1'b0}}, cfg_i.partition_count};
  assign top        = (32'(cfg_i.partition_count) > 32'(TopMax)) ? IdxW'(TopMax)
                                                                  : cnt_wide[IdxW-1:0];
  assign sector     = cfg_i.block_addressed ? in_i.address
                                            : (in_i.address >> SECTOR_SHIFT);
  assign hit        = addr_q >= ram_rdata_i[ADDR_W-1:0];
  assign out_free   = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (act == ACT_CHECK && !cfg_i.force_allow && top != '0) begin
            state_d = ST_SCAN;
          end else if ((act inside {ACT_MARK_WR, ACT_MARK_RO}) && in_range) begin
            state_d = ST_MARK;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MARK: state_d = ST_DONE;
      ST_SCAN: begin
        if (hit || k_q == IdxW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and ram controls
  always_comb begin
    addr_d      = addr_q;
    k_d         = k_q;
    mark_wr_d   = mark_wr_q;
    res_wr_d    = res_wr_q;
    loaded_d    = loaded_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = k_q;
    ram_wdata_o = {mark_wr_q, ram_rdata_i[ADDR_W-1:0]};
    ram_re_o    = 1'b0;
    ram_raddr_o = k_q;
    out_valid_d = out_valid_q && !out_o.ready;
    writable_d  = writable_q;
    violation_d = violation_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          addr_d    = sector;
          mark_wr_d = (act == ACT_MARK_WR);
          res_wr_d  = 1'b1;
          case (act)
            ACT_CHECK: begin
              k_d         = top;
              ram_re_o    = 1'b1;
              ram_raddr_o = top;
              // no scan without a partition or when forced; writable only if forced
              res_wr_d    = cfg_i.force_allow;
            end
            ACT_LOAD: begin
              if (in_range) begin
                ram_we_o       = 1'b1;
                ram_waddr_o    = idx;
                ram_wdata_o    = {1'b0, in_i.address};
                loaded_d[idx]  = 1'b1;
              end
            end
            default: begin
              // mark: fetch the word so the start sector is kept
              k_d         = idx;
              ram_re_o    = 1'b1;
              ram_raddr_o = idx;
            end
          endcase
        end
      end
      ST_MARK: begin
        ram_we_o      = 1'b1;
        loaded_d[k_q] = 1'b1;
      end
      ST_SCAN: begin
        if (hit) begin
          res_wr_d = loaded_q[k_q] && ram_rdata_i[ADDR_W];
        end else if (k_q == IdxW'(1)) begin
          res_wr_d = 1'b0;
        end else begin
          k_d         = k_q - IdxW'(1);
          ram_re_o    = 1'b1;
          ram_raddr_o = k_q - IdxW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          writable_d  = res_wr_q;
          violation_d = !res_wr_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      loaded_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    k_q         <= k_d;
    mark_wr_q   <= mark_wr_d;
    res_wr_q    <= res_wr_d;
    writable_q  <= writable_d;
    violation_q <= violation_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.writable  = writable_q;
  assign out_o.violation = violation_q;

  `ASSERT_NEVER(a_scan_entry_zero, state_q == ST_SCAN && k_q == '0, "scan reached entry zero")
  `ASSERT_CLK(a_fire_leaves_idle, in_fire |=> state_q != ST_IDLE, "accepted item left idle")
  `ASSERT_CLK(a_mark_one_cycle, state_q == ST_MARK |=> state_q == ST_DONE, "mark write-back stalled")
  `ASSERT_CLK(a_flags_exclusive, out_valid_q |-> writable_q != violation_q, "result flags agree")
  `ASSERT_CLK(a_load_from_done, $rose(out_valid_q) |-> $past(state_q) == ST_DONE,
              "result loaded outside done")

endmodule

[rtl/partition_write_protect_check.sv]
// ---------------------------------------------------------------------------
// partition_write_protect_check
// write guard over a table of partition start sectors with read-only flags
// ---------------------------------------------------------------------------
// steps: loads and forced checks go straight to done; a mark reads the word, then
//   writes it back; a table check scans entries from the highest down to entry 1
// throughput: one item at a time; the scan reads one table word a cycle
//   through the single read port of the table ram
// reset: config goes to force_allow 0, block_addressed 1, partition_count 0;
//   all entries read-only at once, start sectors undefined until loaded
module partition_write_protect_check import pwp_pkg::*; #(
  parameter int unsigned MAX_PARTITIONS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // item channels
  pwp_in_if.sink                in_i,
  pwp_out_if.source             out_o
);

  localparam int unsigned IdxW = $clog2(MAX_PARTITIONS);

  cfg_t              cfg;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IdxW-1:0]   ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // force_allow, block_addressed and partition_count
  pwp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // table word per entry: {writable flag, start sector}
  pwp_ram #(
    .Width (WORD_W),
    .Depth (MAX_PARTITIONS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer: marks as read-modify-write, loads as direct writes, checks scan from
  // the highest partition down; the first entry not above the sector decides
  pwp_scan #(
    .MaxParts (MAX_PARTITIONS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .out_o       (out_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule
